### design/lds_pkg.sv
// Package for the label dominance store: field widths, default sizes and the
// action codes used by the top level and the testbench. No dependencies.
package lds_pkg;

	// Fixed field widths of one input beat
	localparam int ACT_W  = 2;
	localparam int NODE_W = 6;
	localparam int COST_W = 32;
	localparam int TIME_W = 31;
	localparam int LOAD_W = 16;
	localparam int VIS_W  = 64;
	localparam int TOL_W  = 16;

	// Widened limits: cost plus tolerance, time plus tolerance
	localparam int CLIM_W = COST_W + 1;
	localparam int TLIM_W = TIME_W + 1;

	// Default sizes
	localparam int NODE_COUNT_DEF      = 64;
	localparam int LABELS_PER_NODE_DEF = 16;
	localparam int MASK_BITS_DEF       = 64;

	// Tolerance after reset
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD   = 2'd0,
		ACT_CHECK = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

endpackage

### design/label_dominance_store.sv
// Label dominance store: per-node label lists with an add, check and clear.
// Depends on lds_pkg, lds_ram and lds_cmp.
//
// Usage:
//   Input channel: drive action, node_id and the label fields with start high;
//   the beat is taken at a clock edge where start is high and busy is low.
//   busy stays high until the result strobe is issued.
//   Result channel: done is high for exactly one cycle with dominated and
//   status valid; the receiver cannot stall it and must take it then.
//   Config channel: cfg_data is the tolerance; written when cfg_valid and
//   cfg_ready are high. cfg_ready is always high; write only while idle.
// Steps from the accept edge to the edge that takes the result:
//   add, clear, unused action code, out-of-range node or empty check: the
//   count lookup, then the result. check: the count lookup, then one scan
//   step per label examined, until a hit or the end of the list.
//   Throughput: one stored label is read and compared per cycle through the
//   single label RAM port. A new beat may be taken at the edge that ends the
//   done cycle, so an item holds the block for exactly its latency.
// Reset: clears all lists at once (per-node valid bits) and sets tolerance
//   to one; no clearing pass is needed.
module label_dominance_store import lds_pkg::*; #(
	parameter int NODE_COUNT      = NODE_COUNT_DEF,
	parameter int LABELS_PER_NODE = LABELS_PER_NODE_DEF,
	parameter int MASK_BITS       = MASK_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic        [ACT_W-1:0]  action,
	input  logic        [NODE_W-1:0] node_id,
	input  logic signed [COST_W-1:0] path_cost,
	input  logic        [TIME_W-1:0] arrival_time,
	input  logic        [LOAD_W-1:0] load_used,
	input  logic        [VIS_W-1:0]  visited_set,
	output logic                     done,
	output logic                     dominated,
	output logic                     status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic        [TOL_W-1:0]  cfg_data
);

	localparam int DEPTH  = NODE_COUNT * LABELS_PER_NODE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NIDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CNT_W  = $clog2(LABELS_PER_NODE + 1);
	localparam int ROW_W  = COST_W + TIME_W + LOAD_W + MASK_BITS;
	localparam logic [ADDR_W-1:0] LPN_A = ADDR_W'(LABELS_PER_NODE);
	localparam logic [CNT_W-1:0]  LPN_C = CNT_W'(LABELS_PER_NODE);
	localparam logic [NODE_W:0]   NN_C  = (NODE_W + 1)'(NODE_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CNT  = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t state_q;

	// Captured beat
	action_t                  act_q;
	logic        [NODE_W-1:0] node_q;
	logic signed [COST_W-1:0] cost_q;
	logic        [TIME_W-1:0] time_q;
	logic signed [CLIM_W-1:0] cost_lim_q;
	logic        [TLIM_W-1:0] time_lim_q;
	logic        [LOAD_W-1:0] load_q;
	logic     [MASK_BITS-1:0] vis_q;

	logic [TOL_W-1:0]      tol_q;
	logic [NODE_COUNT-1:0] valid_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      issue_k_q;
	logic [ADDR_W-1:0]     base_q;
	logic                  done_q, dom_q, stat_q;

	logic                accept;
	logic [NIDX_W-1:0]   node_idx;
	logic                in_range;
	logic [CNT_W-1:0]    cnt_rd;
	logic [CNT_W-1:0]    cnt_c;
	logic                full_c;
	logic [ADDR_W-1:0]   base_c;
	logic                row_we;
	logic [ADDR_W-1:0]   row_addr;
	logic [ROW_W-1:0]    row_wdata;
	logic [ROW_W-1:0]    row_rdata;
	logic                cnt_we;
	logic [NIDX_W-1:0]   cnt_addr;
	logic                match;
	logic signed [COST_W-1:0] st_cost;
	logic        [TIME_W-1:0] st_time;
	logic        [LOAD_W-1:0] st_load;
	logic     [MASK_BITS-1:0] st_vis;

	assign accept    = start & (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign dominated = dom_q;
	assign status    = stat_q;

	// Decode the captured node and its label count
	always_comb begin
		node_idx = node_q[NIDX_W-1:0];
		in_range = ({1'b0, node_q} < NN_C);
		cnt_c    = (in_range && valid_q[node_idx]) ? cnt_rd : '0;
		full_c   = (cnt_c >= LPN_C);
		base_c   = ADDR_W'(node_idx) * LPN_A;
	end

	// Drive the RAM ports: count RAM read at accept, written in the count step
	always_comb begin
		cnt_addr  = (state_q == ST_IDLE) ? node_id[NIDX_W-1:0] : node_idx;
		cnt_we    = (state_q == ST_CNT) && (act_q == ACT_ADD) && in_range && !full_c;
		row_we    = cnt_we;
		row_wdata = {cost_q, time_q, load_q, vis_q};
		if (state_q == ST_CNT) begin
			row_addr = base_c + ((act_q == ACT_ADD) ? ADDR_W'(cnt_c) : '0);
		end else begin
			row_addr = base_q + ADDR_W'(issue_k_q);
		end
	end

	// Row layout: cost, time, load, mask
	assign {st_cost, st_time, st_load, st_vis} = row_rdata;

	lds_ram #(
		.WIDTH(ROW_W),
		.DEPTH(DEPTH)
	) u_rows (
		.clk  (clk),
		.we   (row_we),
		.addr (row_addr),
		.wdata(row_wdata),
		.rdata(row_rdata)
	);

	lds_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NODE_COUNT)
	) u_counts (
		.clk  (clk),
		.we   (cnt_we),
		.addr (cnt_addr),
		.wdata(cnt_c + CNT_W'(1)),
		.rdata(cnt_rd)
	);

	lds_cmp #(
		.MASK_BITS(MASK_BITS)
	) u_cmp (
		.st_cost (st_cost),
		.st_time (st_time),
		.st_load (st_load),
		.st_vis  (st_vis),
		.cost_lim(cost_lim_q),
		.time_lim(time_lim_q),
		.new_load(load_q),
		.new_vis (vis_q),
		.match   (match)
	);

	// Hold the tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// Capture the beat and form the widened limits
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= action_t'(action);
			node_q     <= node_id;
			cost_q     <= path_cost;
			time_q     <= arrival_time;
			load_q     <= load_used;
			vis_q      <= visited_set[MASK_BITS-1:0];
			cost_lim_q <= CLIM_W'(path_cost) + $signed(CLIM_W'({1'b0, tol_q}));
			time_lim_q <= TLIM_W'(arrival_time) + TLIM_W'(tol_q);
		end
		if (state_q == ST_CNT) begin
			cnt_q  <= cnt_c;
			base_q <= base_c;
		end
	end

	// Sequencer: count lookup, then for a check one stored label per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			issue_k_q <= '0;
			done_q    <= 1'b0;
			dom_q     <= 1'b0;
			stat_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					dom_q     <= 1'b0;
					stat_q    <= (act_q == ACT_ADD) && (!in_range || full_c);
					issue_k_q <= CNT_W'(1);
					if (act_q == ACT_CHECK && in_range && cnt_c != '0) begin
						state_q <= ST_SCAN;
						done_q  <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						if (act_q == ACT_ADD) begin
							if (in_range && !full_c) begin
								valid_q[node_idx] <= 1'b1;
							end
						end else if (act_q == ACT_CLEAR) begin
							valid_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						dom_q   <= 1'b1;
					end else if (issue_k_q == cnt_q) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						done_q    <= 1'b0;
						issue_k_q <= issue_k_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

### design/lds_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the label rows and the per-node label counts.
module lds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, register the read word every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### design/lds_cmp.sv
// Shared dominance compare: tests one stored label against the limits of the
// new label. Depends on lds_pkg for the field widths.
module lds_cmp import lds_pkg::*; #(
	parameter int MASK_BITS = MASK_BITS_DEF
) (
	input  logic signed [COST_W-1:0] st_cost,
	input  logic        [TIME_W-1:0] st_time,
	input  logic        [LOAD_W-1:0] st_load,
	input  logic     [MASK_BITS-1:0] st_vis,
	input  logic signed [CLIM_W-1:0] cost_lim,
	input  logic        [TLIM_W-1:0] time_lim,
	input  logic        [LOAD_W-1:0] new_load,
	input  logic     [MASK_BITS-1:0] new_vis,
	output logic                     match
);

	logic signed [CLIM_W-1:0] st_cost_x;
	logic        [TLIM_W-1:0] st_time_x;
	logic cost_ok, time_ok, load_ok, vis_ok;

	// Widen stored values to the limit widths, then compare each resource
	always_comb begin
		st_cost_x = CLIM_W'(st_cost);
		st_time_x = {1'b0, st_time};
		cost_ok   = (st_cost_x <= cost_lim);
		time_ok   = (st_time_x <= time_lim);
		load_ok   = (st_load <= new_load);
		vis_ok    = ((st_vis & ~new_vis) == '0);
		match     = cost_ok & time_ok & load_ok & vis_ok;
	end

endmodule

### test/tb_label_dominance_store.sv
// Testbench for label_dominance_store: sends add, check, clear and unused-code beats and
// compares every result strobe with a behavioral model of the per-node lists.
// Depends on lds_pkg and the label_dominance_store RTL.
module tb_label_dominance_store;
	timeunit 1ns;
	timeprecision 1ps;

	import lds_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int NODES        = NODE_COUNT_DEF;
	localparam int LPN          = LABELS_PER_NODE_DEF;
	localparam int PHASE_ITEMS  = 185;
	localparam int NUM_PHASES   = 5;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;

	localparam longint COST_LO = -64'sd2147483648;
	localparam longint COST_HI = 64'sd2147483647;
	localparam longint TIME_HI = 64'sd2147483647;

	typedef struct {
		action_t                  act;
		logic [NODE_W-1:0]        node;
		logic signed [COST_W-1:0] cost;
		logic [TIME_W-1:0]        arrive;
		logic [LOAD_W-1:0]        load;
		logic [VIS_W-1:0]         visited;
	} label_cmd_t;

	typedef struct {
		action_t           act;
		logic [NODE_W-1:0] node;
		logic              dom;
		logic              dropped;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [ACT_W-1:0] action = '0;
	logic [NODE_W-1:0] node_id = '0;
	logic signed [COST_W-1:0] path_cost = '0;
	logic [TIME_W-1:0] arrival_time = '0;
	logic [LOAD_W-1:0] load_used = '0;
	logic [VIS_W-1:0] visited_set = '0;
	logic done;
	logic dominated;
	logic status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [TOL_W-1:0] cfg_data = '0;

	label_dominance_store u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.node_id      (node_id),
		.path_cost    (path_cost),
		.arrival_time (arrival_time),
		.load_used    (load_used),
		.visited_set  (visited_set),
		.done         (done),
		.dominated    (dominated),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Label list model, updated at each accepted beat
	logic signed [COST_W-1:0] lbl_cost [NODES*LPN];
	logic [TIME_W-1:0]        lbl_time [NODES*LPN];
	logic [LOAD_W-1:0]        lbl_load [NODES*LPN];
	logic [VIS_W-1:0]         lbl_mask [NODES*LPN];
	int                       lbl_count [NODES];
	logic [TOL_W-1:0]         tol_now = TOL_RESET;

	verdict_t   verdict_q[$];
	label_cmd_t beat_q[$];

	// Stimulus-side view of the lists, used to aim checks at stored labels
	label_cmd_t       plan_lbl [NODES][LPN];
	int               plan_cnt [NODES];
	logic [TOL_W-1:0] plan_tol = TOL_RESET;
	int               hot [3];
	int               phase_count;

	label_cmd_t  cur_cmd;
	int          gap_left = 0;
	int          burst_left = 0;
	int          mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_cnt++;
	endtask

	// Apply one beat to the list model and queue the result it must produce
	function automatic void resolve_label_action(label_cmd_t c);
		verdict_t v;
		int base;
		longint cost_lim;
		longint time_lim;
		v.act = c.act;
		v.node = c.node;
		v.dom = 1'b0;
		v.dropped = 1'b0;
		base = int'(c.node) * LPN;
		case (c.act)
			ACT_ADD: begin
				if (lbl_count[c.node] >= LPN) begin
					v.dropped = 1'b1;
				end else begin
					lbl_cost[base + lbl_count[c.node]] = c.cost;
					lbl_time[base + lbl_count[c.node]] = c.arrive;
					lbl_load[base + lbl_count[c.node]] = c.load;
					lbl_mask[base + lbl_count[c.node]] = c.visited;
					lbl_count[c.node]++;
				end
			end
			ACT_CHECK: begin
				cost_lim = longint'(c.cost) + longint'(tol_now);
				time_lim = longint'(c.arrive) + longint'(tol_now);
				for (int k = 0; k < lbl_count[c.node]; k++) begin
					if (longint'(lbl_cost[base + k]) <= cost_lim &&
					    longint'(lbl_time[base + k]) <= time_lim &&
					    lbl_load[base + k] <= c.load &&
					    (lbl_mask[base + k] & c.visited) == lbl_mask[base + k])
						v.dom = 1'b1;
				end
			end
			ACT_CLEAR: begin
				for (int n = 0; n < NODES; n++)
					lbl_count[n] = 0;
			end
			default: ;
		endcase
		verdict_q.insert(verdict_q.size(), v);
	endfunction

	function automatic label_cmd_t mk_cmd(action_t a, int node, logic signed [COST_W-1:0] cost,
	                                      logic [TIME_W-1:0] t, logic [LOAD_W-1:0] ld,
	                                      logic [VIS_W-1:0] m);
		label_cmd_t c;
		c.act = a;
		c.node = node[NODE_W-1:0];
		c.cost = cost;
		c.arrive = t;
		c.load = ld;
		c.visited = m;
		return c;
	endfunction

	// Queue a beat for the driver and track what the lists will hold
	function automatic void queue_cmd(label_cmd_t c);
		beat_q.insert(beat_q.size(), c);
		if (c.act != ACT_NONE)
			phase_count++;
		if (c.act == ACT_ADD && plan_cnt[c.node] < LPN) begin
			plan_lbl[c.node][plan_cnt[c.node]] = c;
			plan_cnt[c.node]++;
		end else if (c.act == ACT_CLEAR) begin
			for (int n = 0; n < NODES; n++)
				plan_cnt[n] = 0;
		end
	endfunction

	// Random label: mostly clustered values, sometimes full range or extremes
	function automatic label_cmd_t rand_label(action_t a, int node);
		label_cmd_t c;
		c.act = a;
		c.node = node[NODE_W-1:0];
		case ($urandom_range(0, 5))
			0: c.cost = $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: c.cost = 32'sh8000_0000;
					1: c.cost = 32'sh7FFF_FFFF;
					2: c.cost = '0;
					default: c.cost = '1;
				endcase
			end
			default: c.cost = $urandom_range(0, 8191) - 4096;
		endcase
		case ($urandom_range(0, 5))
			0: c.arrive = TIME_W'($urandom);
			1: c.arrive = $urandom_range(0, 1) ? '1 : '0;
			default: c.arrive = TIME_W'($urandom_range(0, 8191));
		endcase
		case ($urandom_range(0, 5))
			0: c.load = LOAD_W'($urandom);
			1: c.load = $urandom_range(0, 1) ? '1 : '0;
			default: c.load = LOAD_W'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 5))
			0: c.visited = {$urandom, $urandom};
			1: c.visited = $urandom_range(0, 1) ? '1 : '0;
			default: c.visited = {$urandom, $urandom} & {$urandom, $urandom};
		endcase
		return c;
	endfunction

	// Check aimed at a stored label: values at, just past or near its limits
	function automatic label_cmd_t near_check(int node);
		label_cmd_t c;
		label_cmd_t anchor;
		longint v;
		int ld;
		int b;
		c = rand_label(ACT_CHECK, node);
		if (plan_cnt[node] == 0)
			return c;
		anchor = plan_lbl[node][$urandom_range(0, plan_cnt[node] - 1)];

		case ($urandom_range(0, 4))
			0: v = longint'(anchor.cost) - longint'(plan_tol);
			1: v = longint'(anchor.cost) - longint'(plan_tol) - 1;
			2: v = longint'(anchor.cost) + longint'($urandom_range(0, 100));
			3: v = longint'(anchor.cost);
			default: v = longint'(c.cost);
		endcase
		c.cost = (v < COST_LO || v > COST_HI) ? anchor.cost : v[COST_W-1:0];

		case ($urandom_range(0, 4))
			0: v = longint'(anchor.arrive) - longint'(plan_tol);
			1: v = longint'(anchor.arrive) - longint'(plan_tol) - 1;
			2: v = longint'(anchor.arrive) + longint'($urandom_range(0, 100));
			3: v = longint'(anchor.arrive);
			default: v = longint'(c.arrive);
		endcase
		c.arrive = (v < 0 || v > TIME_HI) ? anchor.arrive : v[TIME_W-1:0];

		case ($urandom_range(0, 3))
			0: ld = int'(anchor.load);
			1: ld = (anchor.load == 0) ? 0 : int'(anchor.load) - 1;
			2: ld = int'(anchor.load) + int'($urandom_range(0, 20));
			default: ld = int'(c.load);
		endcase
		c.load = (ld > 65535) ? '1 : ld[LOAD_W-1:0];

		case ($urandom_range(0, 4))
			0, 1, 2: c.visited = anchor.visited | ({$urandom, $urandom} & {$urandom, $urandom});
			3: begin
				b = $urandom_range(0, VIS_W - 1);
				c.visited = anchor.visited;
				c.visited[b] = 1'b0;
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic int pick_node();
		if ($urandom_range(0, 9) < 7)
			return hot[$urandom_range(0, 2)];
		return $urandom_range(0, NODES - 1);
	endfunction

	// Idle cycles after a beat: mostly none or short, a few long, some bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (beat_q.size() != 0 || start || verdict_q.size() != 0 || busy !== 1'b0);
	endtask

	task automatic write_tolerance(logic [TOL_W-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		plan_tol = v;
		@(negedge clk);
	endtask

	// Sequences on a few hot nodes, list fills, clears and stray beats
	task automatic run_random_phase();
		int node;
		int n;
		int r;
		phase_count = 0;
		for (int h = 0; h < 3; h++)
			hot[h] = $urandom_range(0, NODES - 1);
		while (phase_count < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			node = pick_node();
			if (r < 60) begin
				n = $urandom_range(2, 12);
				repeat (n) begin
					if ($urandom_range(0, 2) == 0)
						queue_cmd(rand_label(ACT_ADD, node));
					else
						queue_cmd(near_check(node));
				end
			end else if (r < 70) begin
				n = LPN + 2 - plan_cnt[node];
				repeat (n)
					queue_cmd(rand_label(ACT_ADD, node));
				repeat (3)
					queue_cmd(near_check(node));
			end else if (r < 74) begin
				queue_cmd(rand_label(ACT_CLEAR, node));
			end else if (r < 78) begin
				queue_cmd(rand_label(ACT_NONE, node));
			end else begin
				queue_cmd(rand_label(action_t'($urandom_range(0, 1)),
				                     $urandom_range(0, NODES - 1)));
			end
		end
	endtask

	// Driver: hold a beat until taken, then idle or launch the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready === 1'b1)
				tol_now = cfg_data;
			if (start && busy === 1'b0)
				resolve_label_action(cur_cmd);
			if (start && busy !== 1'b0) begin
				// hold the current beat
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (beat_q.size() > 0) begin
				cur_cmd = beat_q.pop_front();
				action <= cur_cmd.act;
				node_id <= cur_cmd.node;
				path_cost <= cur_cmd.cost;
				arrival_time <= cur_cmd.arrive;
				load_used <= cur_cmd.load;
				visited_set <= cur_cmd.visited;
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result strobe with the oldest expectation
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done === 1'b1) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("result strobe with no beat outstanding");
			end else begin
				want = verdict_q.pop_front();
				if (dominated !== want.dom)
					report_mismatch($sformatf("%s node %0d: dominated %b, want %b",
					                          want.act.name(), want.node, dominated, want.dom));
				if (status !== want.dropped)
					report_mismatch($sformatf("%s node %0d: status %b, want %b",
					                          want.act.name(), want.node, status, want.dropped));
			end
		end
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("label_dominance_store verification failed");
		$finish;
	end

	initial begin
		label_cmd_t top_lbl;
		logic [TOL_W-1:0] phase_tol [NUM_PHASES];
		phase_tol[0] = '0;
		phase_tol[1] = '1;
		phase_tol[2] = TOL_W'($urandom_range(0, 65535));
		phase_tol[3] = 16'd1;
		phase_tol[4] = TOL_W'($urandom_range(0, 65535));
		for (int n = 0; n < NODES; n++)
			plan_cnt[n] = 0;

		// Fill node 0 with top-of-range labels, then one add too many
		top_lbl = mk_cmd(ACT_ADD, 0, 32'sh7FFF_FFFF, '1, '1, '1);
		repeat (LPN + 1)
			queue_cmd(top_lbl);
		// Checks near the limit of each resource; the misses walk the full list
		queue_cmd(mk_cmd(ACT_CHECK, 0, 32'sh7FFF_FFFF, '1, '1, '1));
		queue_cmd(mk_cmd(ACT_CHECK, 0, 32'sh7FFF_FFFE, '1, '1, '1));
		queue_cmd(mk_cmd(ACT_CHECK, 0, 32'sh7FFF_FFFD, '1, '1, '1));
		queue_cmd(mk_cmd(ACT_CHECK, 0, 32'sh7FFF_FFFF, 31'h7FFF_FFFD, '1, '1));
		queue_cmd(mk_cmd(ACT_CHECK, 0, 32'sh7FFF_FFFF, '1, 16'hFFFE, '1));
		queue_cmd(mk_cmd(ACT_CHECK, 0, 32'sh7FFF_FFFF, '1, '1, {1'b0, {(VIS_W-1){1'b1}}}));
		// Bottom-of-range label on the last node, empty mask
		queue_cmd(mk_cmd(ACT_ADD, NODES - 1, 32'sh8000_0000, '0, '0, '0));
		queue_cmd(mk_cmd(ACT_CHECK, NODES - 1, 32'sh8000_0000, '0, '0, '0));
		// Unused action code, then clear and look again
		queue_cmd(mk_cmd(ACT_NONE, NODES - 1, '1, '1, '1, '1));
		queue_cmd(mk_cmd(ACT_CLEAR, 0, '0, '0, '0, '0));
		queue_cmd(mk_cmd(ACT_CHECK, 0, 32'sh7FFF_FFFF, '1, '1, '1));

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_tolerance(phase_tol[p]);
			run_random_phase();
		end

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_cnt == 0)
			$display("label_dominance_store verification clean");
		else
			$display("label_dominance_store verification failed");
		$finish;
	end

endmodule

### files.f
design/lds_pkg.sv
design/lds_ram.sv
design/lds_cmp.sv
design/label_dominance_store.sv
test/tb_label_dominance_store.sv
